[src/cdf_pkg.sv]
// ----------------------------------------------------------------------------
// cdf_pkg
// Shared types and codes of the CRC-8 packet deframer.
// ----------------------------------------------------------------------------
package cdf_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] status_t;
  typedef logic [0:0] cfg_addr_t;

  // closing status codes, also used for the stored header error
  localparam status_t STAT_OK        = 2'd0;
  localparam status_t STAT_BAD_START = 2'd1;
  localparam status_t STAT_BAD_LEN   = 2'd2;
  localparam status_t STAT_BAD_CRC   = 2'd3;

  // configuration register indexes
  localparam cfg_addr_t REG_START_BYTE   = 1'd0;
  localparam cfg_addr_t REG_EXPECTED_LEN = 1'd1;

  localparam int    LEN_W    = 5;
  localparam byte_t CRC_POLY = 8'h07;

endpackage

[src/cdf_if.sv]
// ----------------------------------------------------------------------------
// cdf interfaces
// Valid/ready channels for received bytes, results and register writes.
// ----------------------------------------------------------------------------
interface cdf_in_if import cdf_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t rx_byte;
  logic  first;

  modport source (output valid, output rx_byte, output first, input ready);
  modport sink   (input valid, input rx_byte, input first, output ready);
endinterface

interface cdf_out_if import cdf_pkg::*; ();
  logic    valid;
  logic    ready;
  byte_t   out_byte;
  logic    is_end;
  status_t status;

  modport source (output valid, output out_byte, output is_end, output status, input ready);
  modport sink   (input valid, input out_byte, input is_end, input status, output ready);
endinterface

interface cdf_cfg_if import cdf_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_addr_t addr;
  byte_t     data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

[src/crc8_packet_deframer_top.sv]
// ----------------------------------------------------------------------------
// crc8_packet_deframer_top
// Latency: a result is presented in the cycle after its byte request is taken.
// Throughput: one byte per cycle while no result is pending or the pending one is
// taken; the byte-wide CRC XOR network and the frame state update are combinational.
// Reset (rst_n, synchronous): frame idle, CRC cleared, start byte 0,
// expected length 24, no result pending.
// ----------------------------------------------------------------------------
module crc8_packet_deframer_top
  import cdf_pkg::*;
#(
  parameter int MAX_PAYLOAD = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  cdf_in_if.sink    in_ch,
  cdf_out_if.source out_ch,
  cdf_cfg_if.sink   cfg_ch
);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

  function automatic byte_t crc8_update(input byte_t c_in, input byte_t d);
    byte_t c;
    c = c_in ^ d;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) c = {c[6:0], 1'b0} ^ CRC_POLY;
      else      c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // configuration
  byte_t            start_byte_r;
  logic [LEN_W-1:0] expected_len_r;

  // frame state
  logic [LEN_W-1:0] pos_r, pos_nxt;
  byte_t            crc_r, crc_nxt;
  status_t          herr_r, herr_nxt;
  logic             active_r, active_nxt;

  // result register
  logic    out_valid_r;
  byte_t   out_byte_r, out_byte_nxt;
  logic    is_end_r, is_end_nxt;
  status_t status_r, status_nxt;
  logic    emit;

  logic             in_acc;
  logic [LEN_W-1:0] eff_len;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign eff_len      = (expected_len_r > MAX_LEN) ? MAX_LEN : expected_len_r;

  always_comb begin
    pos_nxt      = pos_r;
    crc_nxt      = crc_r;
    herr_nxt     = herr_r;
    active_nxt   = active_r;
    emit         = 1'b0;
    out_byte_nxt = '0;
    is_end_nxt   = 1'b0;
    status_nxt   = STAT_OK;

    // a first byte restarts the frame and drops any partial one
    if (in_ch.first) begin
      active_nxt = 1'b1;
      pos_nxt    = '0;
      crc_nxt    = '0;
      herr_nxt   = STAT_OK;
    end

    if (active_nxt) begin
      if (pos_nxt == LEN_W'(0)) begin
        herr_nxt = (in_ch.rx_byte != start_byte_r) ? STAT_BAD_START : STAT_OK;
        pos_nxt  = LEN_W'(1);
      end else if (pos_nxt == LEN_W'(1)) begin
        if (herr_nxt == STAT_OK && in_ch.rx_byte != {3'b000, eff_len}) begin
          herr_nxt = STAT_BAD_LEN;
        end
        pos_nxt = LEN_W'(2);
      end else if ({1'b0, pos_nxt} < ({1'b0, eff_len} + (LEN_W+1)'(2))) begin
        crc_nxt = crc8_update(crc_nxt, in_ch.rx_byte);
        if (herr_nxt == STAT_OK) begin
          emit         = 1'b1;
          out_byte_nxt = in_ch.rx_byte;
        end
        pos_nxt = pos_nxt + LEN_W'(1);
      end else begin
        // crc byte closes the frame
        emit       = 1'b1;
        is_end_nxt = 1'b1;
        if (herr_nxt != STAT_OK) status_nxt = herr_nxt;
        else if (in_ch.rx_byte != crc_nxt) status_nxt = STAT_BAD_CRC;
        else status_nxt = STAT_OK;
        active_nxt = 1'b0;
        pos_nxt    = '0;
        crc_nxt    = '0;
        herr_nxt   = STAT_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r   <= '0;
      expected_len_r <= LEN_W'(24);
      pos_r          <= '0;
      crc_r          <= '0;
      herr_r         <= STAT_OK;
      active_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.addr)
          REG_START_BYTE:   start_byte_r   <= cfg_ch.data;
          REG_EXPECTED_LEN: expected_len_r <= cfg_ch.data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        pos_r       <= pos_nxt;
        crc_r       <= crc_nxt;
        herr_r      <= herr_nxt;
        active_r    <= active_nxt;
        out_valid_r <= emit;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_byte_r <= out_byte_nxt;
      is_end_r   <= is_end_nxt;
      status_r   <= status_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.is_end   = is_end_r;
  assign out_ch.status   = status_r;

endmodule

[src/cdf_checker.sv]
// ----------------------------------------------------------------------------
// cdf_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module cdf_checker
  import cdf_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input byte_t   out_byte,
  input logic    is_end,
  input status_t status
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(is_end))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  a_free_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_end |-> out_byte == 8'h00)
    else $error("closing result carries a byte");

  a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_end |-> status == STAT_OK)
    else $error("payload result carries a status");

endmodule

bind crc8_packet_deframer_top cdf_checker u_cdf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .is_end    (out_ch.is_end),
  .status    (out_ch.status)
);

[tb/sv/crc8_deframer_checker.sv]
// ----------------------------------------------------------------------------
// crc8_deframer_checker
// Watches the byte, result and register channels of the deframer, keeps its
// own frame state and CRC-8, and compares each result taken with the oldest
// predicted one.
// ----------------------------------------------------------------------------
module crc8_deframer_checker
  import cdf_pkg::*;
#(
  parameter int MAX_PAYLOAD = 24
) (
  input  logic clk,
  input  logic rst_n,
  cdf_in_if    in_ch,
  cdf_out_if   out_ch,
  cdf_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending,
  output int   results_seen,
  output int   frames_closed,
  output int   frames_clean
);

  typedef struct packed {
    byte_t   data;
    logic    is_end;
    status_t status;
  } frame_res_t;

  frame_res_t             expected_res_q[$];

  byte_t                  start_byte;
  logic [LEN_W-1:0]       expected_len;
  logic [LEN_W-1:0]       pos;
  byte_t                  crc;
  status_t                hdr_err;
  logic                   active;

  function automatic byte_t crc8_next(input byte_t c, input byte_t d);
    byte_t v;
    v = c ^ d;
    for (int b = 0; b < 8; b++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

  // advances the frame state by one byte, returns 1 when a result is due
  function automatic bit deframe_byte(input byte_t rx, input logic first,
                                      output frame_res_t res);
    int lim;
    bit produced;
    lim      = (int'(expected_len) > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(expected_len);
    res      = '0;
    produced = 1'b0;
    if (first) begin
      active  = 1'b1;
      pos     = '0;
      crc     = '0;
      hdr_err = STAT_OK;
    end
    if (active) begin
      if (pos == 0) begin
        hdr_err = (rx != start_byte) ? STAT_BAD_START : STAT_OK;
        pos     = LEN_W'(1);
      end else if (pos == 1) begin
        if (hdr_err == STAT_OK && int'(rx) != lim) hdr_err = STAT_BAD_LEN;
        pos = LEN_W'(2);
      end else if (int'(pos) < lim + 2) begin
        crc = crc8_next(crc, rx);
        pos = pos + 1'b1;
        if (hdr_err == STAT_OK) begin
          res.data = rx;
          produced = 1'b1;
        end
      end else begin
        // crc byte closes the frame, header errors win over a crc mismatch
        res.is_end = 1'b1;
        if (hdr_err != STAT_OK) res.status = hdr_err;
        else res.status = (rx != crc) ? STAT_BAD_CRC : STAT_OK;
        active   = 1'b0;
        pos      = '0;
        crc      = '0;
        hdr_err  = STAT_OK;
        produced = 1'b1;
      end
    end
    return produced;
  endfunction

  always @(posedge clk) begin
    frame_res_t got;
    frame_res_t want;
    frame_res_t nxt;
    if (!rst_n) begin
      start_byte    = 8'h00;
      expected_len  = 5'd24;
      pos           = '0;
      crc           = '0;
      hdr_err       = STAT_OK;
      active        = 1'b0;
      fail_count    = 0;
      results_seen  = 0;
      frames_closed = 0;
      frames_clean  = 0;
      expected_res_q.delete();
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.data   = out_ch.out_byte;
        got.is_end = out_ch.is_end;
        got.status = out_ch.status;
        results_seen++;
        if (expected_res_q.size() == 0) begin
          $error("result with no request waiting: out_byte %0h is_end %0b status %0d",
                 got.data, got.is_end, got.status);
          fail_count++;
        end else begin
          want = expected_res_q.pop_front();
          if (got.data !== want.data) begin
            $error("out_byte: expected %0h, got %0h", want.data, got.data);
            fail_count++;
          end
          if (got.is_end !== want.is_end) begin
            $error("is_end: expected %0b, got %0b", want.is_end, got.is_end);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (want.is_end) begin
            frames_closed++;
            if (want.status == STAT_OK) frames_clean++;
          end
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        if (deframe_byte(in_ch.rx_byte, in_ch.first, nxt)) expected_res_q.push_back(nxt);
      end
      if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) begin
        if (cfg_ch.addr == REG_START_BYTE) start_byte = cfg_ch.data;
        else if (cfg_ch.addr == REG_EXPECTED_LEN) expected_len = cfg_ch.data[LEN_W-1:0];
      end
    end
    pending = expected_res_q.size();
  end

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives received bytes and register writes into the CRC-8 packet deframer
// with random idling on both sides; the checker beside it predicts results.
// ----------------------------------------------------------------------------
module tb_top;
  import cdf_pkg::*;

  localparam int MAX_PAYLOAD = 24;
  localparam int RX_BYTES    = 1200;
  localparam int PHASE_BYTES = 150;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 500000;

  logic             clk;
  logic             rst_n = 1'b0;

  int               fail_count;
  int               pending;
  int               results_seen;
  int               frames_closed;
  int               frames_clean;

  int               cycle_cnt    = 0;
  int               bytes_sent   = 0;
  int               frame_bytes  = 0;
  int               rx_hold_reqs = 0;
  bit               steady       = 1'b0;
  byte_t            cfg_start;
  logic [LEN_W-1:0] cfg_len;

  cdf_in_if  in_ch  ();
  cdf_out_if out_ch ();
  cdf_cfg_if cfg_ch ();

  crc8_packet_deframer_top #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  crc8_deframer_checker #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .results_seen  (results_seen),
    .frames_closed (frames_closed),
    .frames_clean  (frames_clean)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // mostly no gap, some short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic byte_t crc_step(input byte_t c, input byte_t d);
    byte_t v;
    v = c ^ d;
    for (int b = 0; b < 8; b++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

  function automatic int eff_len();
    return (int'(cfg_len) > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(cfg_len);
  endfunction

  task automatic send_byte(input byte_t b, input logic f);
    int gap;
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    in_ch.first   <= f;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    bytes_sent++;
    gap = steady ? 0 : gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // one edge first so the last request has reached the checker
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_config(input byte_t sb, input logic [LEN_W-1:0] ln);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= REG_START_BYTE;
    cfg_ch.data  <= sb;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    // upper bits of the length write are don't-care
    cfg_ch.addr  <= REG_EXPECTED_LEN;
    cfg_ch.data  <= {3'($urandom_range(0, 7)), ln};
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    cfg_start = sb;
    cfg_len   = ln;
  endtask

  // start, length, n payload bytes, crc; cut > 0 drops the frame after cut bytes
  task automatic send_frame(input byte_t sb, input byte_t lb, input int n,
                            input bit bad_crc, input int cut);
    byte_t crc;
    byte_t b;
    crc = '0;
    for (int k = 0; k < n + 3; k++) begin
      if (cut > 0 && k >= cut) break;
      if (k == 0) b = sb;
      else if (k == 1) b = lb;
      else if (k < n + 2) begin
        b   = byte_t'($urandom_range(0, 255));
        crc = crc_step(crc, b);
      end else begin
        b = bad_crc ? (crc ^ byte_t'($urandom_range(1, 255))) : crc;
      end
      send_byte(b, k == 0);
      frame_bytes++;
    end
  endtask

  task automatic send_random_item();
    int    r;
    int    lim;
    byte_t lb;
    r   = $urandom_range(0, 99);
    lim = eff_len();
    if (r < 70) begin
      send_frame(cfg_start, byte_t'(lim), lim, $urandom_range(0, 6) == 0, 0);
    end else if (r < 76) begin
      lb = $urandom_range(0, 1) ? byte_t'(lim) : byte_t'($urandom_range(0, 255));
      send_frame(cfg_start ^ byte_t'($urandom_range(1, 255)), lb, lim,
                 bit'($urandom_range(0, 1)), 0);
    end else if (r < 82) begin
      send_frame(cfg_start, byte_t'(lim + $urandom_range(1, 255)), lim,
                 bit'($urandom_range(0, 1)), 0);
    end else if (r < 88) begin
      send_frame(cfg_start, byte_t'(lim), lim, 1'b0, $urandom_range(1, lim + 2));
    end else if (r < 94) begin
      // first=0 bytes: ignored when idle, but they extend a dropped frame
      repeat ($urandom_range(1, 4)) send_byte(byte_t'($urandom_range(0, 255)), 1'b0);
    end else begin
      repeat ($urandom_range(1, 6)) begin
        send_byte(byte_t'($urandom_range(0, 255)), logic'($urandom_range(0, 1)));
        frame_bytes++;
      end
    end
  endtask

  // receiver: random back-pressure plus requested long holds
  initial begin
    int stall_left;
    int holds_done;
    int g;
    stall_left = 0;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done < rx_hold_reqs) begin
        holds_done++;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (steady) begin
        out_ch.ready <= 1'b1;
      end else begin
        g = gap_len();
        if (g == 0) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          stall_left = g - 1;
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("crc8_packet_deframer_top test failed");
    $finish;
  end

  initial begin
    int    phase;
    int    target;
    byte_t sb;
    int    ln;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    in_ch.first   <= 1'b0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.addr   <= REG_START_BYTE;
    cfg_ch.data   <= 8'h00;
    cfg_start = 8'h00;
    cfg_len   = 5'd24;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames, one payload byte each
    set_config(8'hFF, 5'd1);
    send_byte(8'hFF, 1'b1); send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(crc_step(8'h00, 8'h00), 1'b0);
    // bad start and bad length together: bad start reported
    send_byte(8'h00, 1'b1); send_byte(8'h07, 1'b0);
    send_byte(8'h5A, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1); send_byte(8'h02, 1'b0);
    send_byte(8'h33, 1'b0); send_byte(8'h00, 1'b0);
    // idle byte, then a frame cut short by a restart
    send_byte(8'hC3, 1'b0);
    send_byte(8'hFF, 1'b1); send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b1); send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(crc_step(8'h00, 8'hFF) ^ 8'h01, 1'b0);
    // empty payload
    set_config(8'hFF, 5'd0);
    send_byte(8'hFF, 1'b1); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
    // length raised mid-frame after a header that matched the old length
    send_byte(8'hFF, 1'b1); send_byte(8'h00, 1'b0);
    set_config(8'hFF, 5'd2);
    send_byte(8'h5A, 1'b0); send_byte(8'hA5, 1'b0);
    send_byte(crc_step(crc_step(8'h00, 8'h5A), 8'hA5), 1'b0);

    phase = 0;
    while (frame_bytes < RX_BYTES) begin
      case (phase)
        0: begin sb = 8'h00; ln = 24; end
        1: begin sb = 8'hFF; ln = 1; end
        2: begin sb = byte_t'($urandom_range(0, 255)); ln = 31; end
        3: begin sb = byte_t'($urandom_range(0, 255)); ln = 0; end
        default: begin
          sb = byte_t'($urandom_range(0, 255));
          ln = $urandom_range(0, 31);
        end
      endcase
      set_config(sb, ln[LEN_W-1:0]);
      steady = (phase == 2);
      if (phase == 0) rx_hold_reqs++;
      target = frame_bytes + PHASE_BYTES;
      while (frame_bytes < target && frame_bytes < RX_BYTES) send_random_item();
      phase++;
    end
    steady = 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);
    $display("sent %0d bytes, checked %0d results, %0d frames closed (%0d clean)",
             bytes_sent, results_seen, frames_closed, frames_clean);
    $display("%0d register settings incl. lengths 0, 1, 24, 31; one %0d-cycle output hold",
             phase + 3, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("crc8_packet_deframer_top test passed");
    end else begin
      $display("crc8_packet_deframer_top test failed");
    end
    $finish;
  end

endmodule

[crc8_packet_deframer_top.f]
src/cdf_pkg.sv
src/cdf_if.sv
src/crc8_packet_deframer_top.sv
src/cdf_checker.sv
tb/sv/crc8_deframer_checker.sv
tb/sv/tb_top.sv
